// ===== rtl/sbmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and sign helpers for the segment/box mask test.
// No dependencies; every other file of the block imports this package.
package sbmt_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 4;
    localparam int REG_IDX_W       = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SEG_START_X = 2'd0,
        REG_SEG_START_Y = 2'd1,
        REG_SEG_END_X   = 2'd2,
        REG_SEG_END_Y   = 2'd3
    } t_reg_idx;

    // sign of an exact value: negative, zero, else positive
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sgn;

    // signs of the coordinate compares, carried along the pipeline
    typedef struct packed {
        logic mode;
        t_sgn sxl;   // sx - x_low
        t_sgn sxh;   // sx - x_high
        t_sgn syl;   // sy - y_low
        t_sgn syh;   // sy - y_high
        t_sgn exl;   // ex - x_low
        t_sgn exh;   // ex - x_high
        t_sgn eyl;   // ey - y_low
        t_sgn eyh;   // ey - y_high
        t_sgn wid;   // x_high - x_low
        t_sgn hgt;   // y_high - y_low
    } t_rel;

    // advance enables, one per register stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    function automatic t_sgn sg_mul(input t_sgn a, input t_sgn b);
        t_sgn r;
        r.zero = a.zero | b.zero;
        r.neg  = ~r.zero & (a.neg ^ b.neg);
        return r;
    endfunction

    function automatic t_sgn sg_neg(input t_sgn a);
        t_sgn r;
        r.zero = a.zero;
        r.neg  = ~a.zero & ~a.neg;
        return r;
    endfunction

    // both nonzero and of opposite sign
    function automatic logic sg_opp(input t_sgn a, input t_sgn b);
        return ~a.zero & ~b.zero & (a.neg ^ b.neg);
    endfunction

    // given sgn(p - c) and sgn(q - c): c lies between p and q inclusive
    function automatic logic in_range(input t_sgn a, input t_sgn b);
        logic a_le;
        logic b_le;
        a_le = a.neg | a.zero;
        b_le = b.neg | b.zero;
        return (a_le & ~b.neg) | (b_le & ~a.neg);
    endfunction

endpackage

// ===== rtl/sbmt_cfg_regs.sv =====
`timescale 1ns / 1ps
// Segment endpoint registers behind a simple APB-style port.
// Depends on sbmt_pkg.
module sbmt_cfg_regs #(
    parameter int COORD_WIDTH = sbmt_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbmt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbmt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbmt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic signed [COORD_WIDTH-1:0]   o_seg_start_x,
    output logic signed [COORD_WIDTH-1:0]   o_seg_start_y,
    output logic signed [COORD_WIDTH-1:0]   o_seg_end_x,
    output logic signed [COORD_WIDTH-1:0]   o_seg_end_y
);
    import sbmt_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_sx;
    logic signed [COORD_WIDTH-1:0] r_sy;
    logic signed [COORD_WIDTH-1:0] r_ex;
    logic signed [COORD_WIDTH-1:0] r_ey;
    logic signed [COORD_WIDTH-1:0] n_val;
    t_reg_idx                      idx;
    logic                          wr;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[REG_IDX_W+1:2]);
    assign wr     = psel & penable & pwrite & pready;
    assign n_val  = pwdata[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_SEG_START_X: r_sx <= n_val;
                REG_SEG_START_Y: r_sy <= n_val;
                REG_SEG_END_X:   r_ex <= n_val;
                REG_SEG_END_Y:   r_ey <= n_val;
                default:         r_sx <= r_sx;
            endcase
        end
    end

    // read back sign-extended
    always_comb begin
        unique case (idx)
            REG_SEG_START_X: prdata = APB_DATA_W'(r_sx);
            REG_SEG_START_Y: prdata = APB_DATA_W'(r_sy);
            REG_SEG_END_X:   prdata = APB_DATA_W'(r_ex);
            REG_SEG_END_Y:   prdata = APB_DATA_W'(r_ey);
            default:         prdata = '0;
        endcase
    end

    assign o_seg_start_x = r_sx;
    assign o_seg_start_y = r_sy;
    assign o_seg_end_x   = r_ex;
    assign o_seg_end_y   = r_ey;

endmodule

// ===== rtl/sbmt_prep.sv =====
`timescale 1ns / 1ps
// Stage 1: coordinate differences against the segment and compare signs.
// Depends on sbmt_pkg.
module sbmt_prep #(
    parameter int COORD_WIDTH = sbmt_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_x_low,
    input  logic signed [COORD_WIDTH-1:0] i_x_high,
    input  logic signed [COORD_WIDTH-1:0] i_y_low,
    input  logic signed [COORD_WIDTH-1:0] i_y_high,
    input  logic signed [COORD_WIDTH-1:0] i_sx,
    input  logic signed [COORD_WIDTH-1:0] i_sy,
    input  logic signed [COORD_WIDTH-1:0] i_ex,
    input  logic signed [COORD_WIDTH-1:0] i_ey,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH:0]   o_dx,
    output logic signed [COORD_WIDTH:0]   o_dy,
    output logic signed [COORD_WIDTH:0]   o_dsxl,
    output logic signed [COORD_WIDTH:0]   o_dsxh,
    output logic signed [COORD_WIDTH:0]   o_dsyl,
    output logic signed [COORD_WIDTH:0]   o_dsyh,
    output sbmt_pkg::t_rel                o_rel
);
    import sbmt_pkg::*;

    localparam int W = COORD_WIDTH;

    function automatic t_sgn sgn_of(input logic [W:0] d);
        t_sgn r;
        r.neg  = d[W];
        r.zero = (d == '0);
        return r;
    endfunction

    function automatic logic [W:0] sub(input logic [W-1:0] a, input logic [W-1:0] b);
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    logic signed [W:0] n_dx;
    logic signed [W:0] n_dy;
    logic signed [W:0] n_dsxl;
    logic signed [W:0] n_dsxh;
    logic signed [W:0] n_dsyl;
    logic signed [W:0] n_dsyh;
    t_rel              n_rel;

    logic              r_valid;
    logic signed [W:0] r_dx;
    logic signed [W:0] r_dy;
    logic signed [W:0] r_dsxl;
    logic signed [W:0] r_dsxh;
    logic signed [W:0] r_dsyl;
    logic signed [W:0] r_dsyh;
    t_rel              r_rel;

    always_comb begin
        n_dx   = sub(i_ex, i_sx);
        n_dy   = sub(i_ey, i_sy);
        n_dsxl = sub(i_sx, i_x_low);
        n_dsxh = sub(i_sx, i_x_high);
        n_dsyl = sub(i_sy, i_y_low);
        n_dsyh = sub(i_sy, i_y_high);

        n_rel.mode = i_mode;
        n_rel.sxl  = sgn_of(n_dsxl);
        n_rel.sxh  = sgn_of(n_dsxh);
        n_rel.syl  = sgn_of(n_dsyl);
        n_rel.syh  = sgn_of(n_dsyh);
        n_rel.exl  = sgn_of(sub(i_ex, i_x_low));
        n_rel.exh  = sgn_of(sub(i_ex, i_x_high));
        n_rel.eyl  = sgn_of(sub(i_ey, i_y_low));
        n_rel.eyh  = sgn_of(sub(i_ey, i_y_high));
        n_rel.wid  = sgn_of(sub(i_x_high, i_x_low));
        n_rel.hgt  = sgn_of(sub(i_y_high, i_y_low));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dsxl <= n_dsxl;
            r_dsxh <= n_dsxh;
            r_dsyl <= n_dsyl;
            r_dsyh <= n_dsyh;
            r_rel  <= n_rel;
        end
    end

    assign o_valid = r_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_dsxl  = r_dsxl;
    assign o_dsxh  = r_dsxh;
    assign o_dsyl  = r_dsyl;
    assign o_dsyh  = r_dsyh;
    assign o_rel   = r_rel;

endmodule

// ===== rtl/sbmt_orient.sv =====
`timescale 1ns / 1ps
// Stages 2 and 3: cross products of the segment with the four box corners,
// then their exact signs. Depends on sbmt_pkg.
module sbmt_orient #(
    parameter int COORD_WIDTH = sbmt_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en_a,
    input  logic                        i_en_b,
    input  logic                        i_valid,
    input  logic signed [COORD_WIDTH:0] i_dx,
    input  logic signed [COORD_WIDTH:0] i_dy,
    input  logic signed [COORD_WIDTH:0] i_dsxl,
    input  logic signed [COORD_WIDTH:0] i_dsxh,
    input  logic signed [COORD_WIDTH:0] i_dsyl,
    input  logic signed [COORD_WIDTH:0] i_dsyh,
    input  sbmt_pkg::t_rel              i_rel,
    output logic                        o_valid_a,
    output logic                        o_valid,
    output sbmt_pkg::t_sgn [3:0]        o_corner,
    output sbmt_pkg::t_rel              o_rel
);
    import sbmt_pkg::*;

    localparam int PW = 2 * COORD_WIDTH + 2;   // product width
    localparam int CW = PW + 1;                // cross difference width

    function automatic t_sgn cross_sgn(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [CW-1:0] d;
        t_sgn          r;
        d      = {a[PW-1], a} - {b[PW-1], b};
        r.neg  = d[CW-1];
        r.zero = (d == '0);
        return r;
    endfunction

    logic                 r_valid_a;
    logic signed [PW-1:0] r_pa_l;   // dy * (sx - x_low)
    logic signed [PW-1:0] r_pa_h;   // dy * (sx - x_high)
    logic signed [PW-1:0] r_pb_l;   // dx * (sy - y_low)
    logic signed [PW-1:0] r_pb_h;   // dx * (sy - y_high)
    t_rel                 r_rel_a;

    logic                 r_valid_b;
    t_sgn [3:0]           r_corner;
    t_rel                 r_rel_b;
    t_sgn [3:0]           n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_en_a) begin
                r_valid_a <= i_valid;
            end
            if (i_en_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_pa_l  <= PW'(i_dy) * PW'(i_dsxl);
            r_pa_h  <= PW'(i_dy) * PW'(i_dsxh);
            r_pb_l  <= PW'(i_dx) * PW'(i_dsyl);
            r_pb_h  <= PW'(i_dx) * PW'(i_dsyh);
            r_rel_a <= i_rel;
        end
    end

    // orientation of corner c: dy * (sx - cx) - dx * (sy - cy)
    always_comb begin
        n_corner[0] = cross_sgn(r_pa_l, r_pb_l);   // (x_low,  y_low)
        n_corner[1] = cross_sgn(r_pa_l, r_pb_h);   // (x_low,  y_high)
        n_corner[2] = cross_sgn(r_pa_h, r_pb_h);   // (x_high, y_high)
        n_corner[3] = cross_sgn(r_pa_h, r_pb_l);   // (x_high, y_low)
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_corner <= n_corner;
            r_rel_b  <= r_rel_a;
        end
    end

    assign o_valid_a = r_valid_a;
    assign o_valid   = r_valid_b;
    assign o_corner  = r_corner;
    assign o_rel     = r_rel_b;

endmodule

// ===== rtl/sbmt_decide.sv =====
`timescale 1ns / 1ps
// Stage 4: edge crossing and touch logic, result register.
// Depends on sbmt_pkg.
module sbmt_decide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sbmt_pkg::t_sgn [3:0] i_corner,
    input  sbmt_pkg::t_rel       i_rel,
    output logic                 o_valid,
    output logic                 o_hit
);
    import sbmt_pkg::*;

    logic       r_valid;
    logic       r_hit;
    logic       n_hit;
    logic [3:0] cbox;    // corner inside the segment's bounding box
    t_sgn [3:0] os;      // edge orientation of the segment start
    t_sgn [3:0] oe;      // edge orientation of the segment end
    logic [3:0] sbox;    // start inside the edge's bounding box
    logic [3:0] ebox;    // end inside the edge's bounding box
    logic [3:0] ehit;
    logic       xr_full;
    logic       yr_full;
    logic       xr_full_e;
    logic       yr_full_e;

    always_comb begin
        cbox[0] = in_range(i_rel.sxl, i_rel.exl) & in_range(i_rel.syl, i_rel.eyl);
        cbox[1] = in_range(i_rel.sxl, i_rel.exl) & in_range(i_rel.syh, i_rel.eyh);
        cbox[2] = in_range(i_rel.sxh, i_rel.exh) & in_range(i_rel.syh, i_rel.eyh);
        cbox[3] = in_range(i_rel.sxh, i_rel.exh) & in_range(i_rel.syl, i_rel.eyl);

        // edges: left, top, right, bottom, each from corner k to corner k+1
        os[0] = sg_neg(sg_mul(i_rel.hgt, i_rel.sxl));
        os[1] = sg_mul(i_rel.wid, i_rel.syh);
        os[2] = sg_mul(i_rel.hgt, i_rel.sxh);
        os[3] = sg_neg(sg_mul(i_rel.wid, i_rel.syl));
        oe[0] = sg_neg(sg_mul(i_rel.hgt, i_rel.exl));
        oe[1] = sg_mul(i_rel.wid, i_rel.eyh);
        oe[2] = sg_mul(i_rel.hgt, i_rel.exh);
        oe[3] = sg_neg(sg_mul(i_rel.wid, i_rel.eyl));

        xr_full   = in_range(i_rel.sxl, i_rel.sxh);
        yr_full   = in_range(i_rel.syl, i_rel.syh);
        xr_full_e = in_range(i_rel.exl, i_rel.exh);
        yr_full_e = in_range(i_rel.eyl, i_rel.eyh);

        sbox[0] = i_rel.sxl.zero & yr_full;
        sbox[1] = xr_full & i_rel.syh.zero;
        sbox[2] = i_rel.sxh.zero & yr_full;
        sbox[3] = xr_full & i_rel.syl.zero;
        ebox[0] = i_rel.exl.zero & yr_full_e;
        ebox[1] = xr_full_e & i_rel.eyh.zero;
        ebox[2] = i_rel.exh.zero & yr_full_e;
        ebox[3] = xr_full_e & i_rel.eyl.zero;

        for (int k = 0; k < 4; k++) begin
            ehit[k] = (sg_opp(i_corner[k], i_corner[(k + 1) & 3]) & sg_opp(os[k], oe[k]))
                    | (i_corner[k].zero & cbox[k])
                    | (i_corner[(k + 1) & 3].zero & cbox[(k + 1) & 3])
                    | (os[k].zero & sbox[k])
                    | (oe[k].zero & ebox[k]);
        end

        if (i_rel.mode) begin
            n_hit = |ehit;
        end else begin
            n_hit = i_corner[0].zero & cbox[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

// ===== rtl/segment_box_mask_test.sv =====
`timescale 1ns / 1ps
// Top level of the segment versus point / box outline test.
// Depends on sbmt_pkg, sbmt_cfg_regs, sbmt_prep, sbmt_orient, sbmt_decide.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | i_valid / o_stall    | i_mode, i_x_low, i_x_high, i_y_low, i_y_high
//  result   | o_valid / i_stall    | o_hit
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One request per cycle while o_stall is low, through compare, multiply,
// cross-product sign and edge decision to o_valid. Each stage holds its own
// valid bit and advances when empty or when the stage after it advances, so
// bubbles close up and a stalled result only blocks once every stage is full.
// Synchronous active-low reset clears the valid bits and the segment registers.
module segment_box_mask_test #(
    parameter int COORD_WIDTH = sbmt_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_mode,
    input  logic signed [COORD_WIDTH-1:0]   i_x_low,
    input  logic signed [COORD_WIDTH-1:0]   i_x_high,
    input  logic signed [COORD_WIDTH-1:0]   i_y_low,
    input  logic signed [COORD_WIDTH-1:0]   i_y_high,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbmt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbmt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbmt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sbmt_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] seg_sx;
    logic signed [W-1:0] seg_sy;
    logic signed [W-1:0] seg_ex;
    logic signed [W-1:0] seg_ey;

    t_pipe_en            en;
    logic                v1;
    logic                v2;
    logic                v3;

    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic signed [W:0]   dsxl;
    logic signed [W:0]   dsxh;
    logic signed [W:0]   dsyl;
    logic signed [W:0]   dsyh;
    t_rel                rel1;
    t_rel                rel3;
    t_sgn [3:0]          corner;

    // advance a stage when it is empty or its successor advances
    always_comb begin
        en.s4 = ~o_valid | ~i_stall;
        en.s3 = ~v3 | en.s4;
        en.s2 = ~v2 | en.s3;
        en.s1 = ~v1 | en.s2;
    end

    assign o_stall = ~en.s1;

    sbmt_cfg_regs #(
        .COORD_WIDTH (W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_seg_start_x (seg_sx),
        .o_seg_start_y (seg_sy),
        .o_seg_end_x   (seg_ex),
        .o_seg_end_y   (seg_ey)
    );

    // stage 1: differences and compare signs
    sbmt_prep #(
        .COORD_WIDTH (W)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en.s1),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_x_low  (i_x_low),
        .i_x_high (i_x_high),
        .i_y_low  (i_y_low),
        .i_y_high (i_y_high),
        .i_sx     (seg_sx),
        .i_sy     (seg_sy),
        .i_ex     (seg_ex),
        .i_ey     (seg_ey),
        .o_valid  (v1),
        .o_dx     (dx),
        .o_dy     (dy),
        .o_dsxl   (dsxl),
        .o_dsxh   (dsxh),
        .o_dsyl   (dsyl),
        .o_dsyh   (dsyh),
        .o_rel    (rel1)
    );

    // stages 2 and 3: corner cross products and their signs
    sbmt_orient #(
        .COORD_WIDTH (W)
    ) u_orient (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en_a    (en.s2),
        .i_en_b    (en.s3),
        .i_valid   (v1),
        .i_dx      (dx),
        .i_dy      (dy),
        .i_dsxl    (dsxl),
        .i_dsxh    (dsxh),
        .i_dsyl    (dsyl),
        .i_dsyh    (dsyh),
        .i_rel     (rel1),
        .o_valid_a (v2),
        .o_valid   (v3),
        .o_corner  (corner),
        .o_rel     (rel3)
    );

    // stage 4: edge logic and result register
    sbmt_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en.s4),
        .i_valid  (v3),
        .i_corner (corner),
        .i_rel    (rel3),
        .o_valid  (o_valid),
        .o_hit    (o_hit)
    );

    // back-pressure reaches the request side only with every stage full
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (v1 && v2 && v3 && o_valid))
        else $error("request stalled with an empty stage");

    // an accepted request occupies stage 1 on the next cycle
    a_accept_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> v1)
        else $error("accepted request lost at stage 1");

    // a held result keeps the stage behind it occupied
    a_hold_s3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && v3) |=> (v3 && o_valid))
        else $error("stage 3 dropped while result stalled");

endmodule
